// ===== rtl/core/bounded_deque_with_key_search_assert.svh =====
// Assertion macros for the bounded deque with key search.
// Taken in by `include in the files that assert; no other dependencies.
`ifndef BOUNDED_DEQUE_WITH_KEY_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_KEY_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdq assertion failed");

`endif

// ===== rtl/core/bdq_pkg.sv =====
// Shared types and codes for the bounded deque with key search.
// No dependencies; imported by bdq_rec_ram and bounded_deque_with_key_search.
package bdq_pkg;

    localparam int KEY_BITS    = 32;
    localparam int KIND_BITS   = 3;
    localparam int STATUS_BITS = 2;

    typedef logic [KIND_BITS-1:0]   t_kind;
    typedef logic [STATUS_BITS-1:0] t_status;

    // operation codes carried in tuser
    localparam t_kind KIND_PUSH_FRONT = 3'd0;
    localparam t_kind KIND_PUSH_BACK  = 3'd1;
    localparam t_kind KIND_POP_FRONT  = 3'd2;
    localparam t_kind KIND_POP_BACK   = 3'd3;
    localparam t_kind KIND_FIND       = 3'd4;

    // result status codes
    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_FULL      = 2'd1;
    localparam t_status STATUS_EMPTY     = 2'd2;
    localparam t_status STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/bdq_rec_ram.sv =====
// Record store: one write port, one registered read port returning the key.
// Depends on bdq_pkg for the key width.
module bdq_rec_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int RW          = KEY_BITS + PAYLOAD_BITS
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [RW-1:0]       i_wr_data,   // {payload, key}
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [KEY_BITS-1:0] o_rd_key
);

    logic [RW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // only the key is ever looked at; payload is kept as record state
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key <= r_mem[i_rd_addr][KEY_BITS-1:0];
        end
    end

endmodule

// ===== rtl/core/bounded_deque_with_key_search.sv =====
// Bounded deque of {key, payload} records with front-to-back key search.
// Depends on bdq_pkg, bdq_rec_ram and bounded_deque_with_key_search_assert.svh.
//
// Usage
//  - Slave channel (i_s_*): one command per transfer. tuser carries the kind
//    (push front, push back, pop front, pop back, find); tdata carries key
//    and payload.
//  - Master channel (o_m_*): exactly one result per command: status, the
//    record count after the command, and the 1-based position of a found key.
//  - Push and pop results appear in the cycle after the command transfer.
//  - A find reads the key memory one record per cycle from the front and
//    stops at the first match or after the last record. An empty deque
//    answers a find without a search, with status not found.
//  - The single read port of the record memory sets the search rate; other
//    commands are not taken while a search runs.
//  - Results sit in an output register. A new command is taken while the
//    register is empty or being drained in that same cycle, so a stalled
//    receiver holds off the slave side once one result is waiting.
//  - Reset (i_rst_n low, synchronous) empties the deque and drops any
//    pending result. Memory contents are not cleared: only slots that hold
//    records are ever read.
module bounded_deque_with_key_search
    import bdq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW          = $clog2(DEPTH + 1),
    localparam int IW          = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OW          = ((STATUS_BITS + 2 * CW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IW-1:0]        i_s_tdata,   // key, payload (from bit 0 up)
    input  logic [KIND_BITS-1:0] i_s_tuser,   // kind
    // result channel
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OW-1:0]        o_m_tdata    // status, count, position (from bit 0 up)
);

    `include "bounded_deque_with_key_search_assert.svh"

    // one-hot controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

    t_state r_state, n_state;

    // deque bookkeeping
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // search walk: slot of next read and position of the key now on rd_key
    logic [AW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_pos, n_pos;
    logic [KEY_BITS-1:0] r_find_key, n_find_key;

    // output register
    logic          r_m_valid, n_m_valid;
    t_status       r_status, n_status;
    logic [CW-1:0] r_out_count, n_out_count;
    logic [CW-1:0] r_out_pos, n_out_pos;

    // memory ports
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [KEY_BITS+PAYLOAD_BITS-1:0] wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [KEY_BITS-1:0]          rd_key;

    // command fields
    t_kind                   in_kind;
    logic [KEY_BITS-1:0]     in_key;
    logic [PAYLOAD_BITS-1:0] in_payload;
    logic                    s_xfer;
    logic                    is_full;
    logic                    is_empty;
    logic [CW:0]             back_sum;
    logic [AW-1:0]           back_slot;
    logic [AW-1:0]           front_dec;
    logic [AW-1:0]           front_inc;
    logic [AW-1:0]           slot_inc;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
        ring_inc = (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
        ring_dec = (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
    endfunction

    assign in_kind    = i_s_tuser;
    assign in_key     = i_s_tdata[KEY_BITS-1:0];
    assign in_payload = i_s_tdata[KEY_BITS +: PAYLOAD_BITS];

    // take a command only when idle and the output register is free this cycle
    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign s_xfer     = i_s_tvalid && o_s_tready;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // back slot = (front + count) mod DEPTH; both below DEPTH when not full
    assign back_sum  = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign back_slot = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                    : AW'(back_sum);
    assign front_dec = ring_dec(r_front);
    assign front_inc = ring_inc(r_front);
    assign slot_inc  = ring_inc(r_slot);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_slot      = r_slot;
        n_pos       = r_pos;
        n_find_key  = r_find_key;
        n_m_valid   = r_m_valid;
        n_status    = r_status;
        n_out_count = r_out_count;
        n_out_pos   = r_out_pos;
        wr_en       = 1'b0;
        wr_addr     = front_dec;
        wr_data     = {in_payload, in_key};
        rd_en       = 1'b0;
        rd_addr     = r_slot;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_m_valid   = 1'b1;
                    n_status    = STATUS_OK;
                    n_out_count = r_count;
                    n_out_pos   = '0;
                    case (in_kind)
                        KIND_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = front_dec;
                                n_front     = front_dec;
                                n_count     = r_count + 1'b1;
                                n_out_count = r_count + 1'b1;
                            end
                        end
                        KIND_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = back_slot;
                                n_count     = r_count + 1'b1;
                                n_out_count = r_count + 1'b1;
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_front     = front_inc;
                                n_count     = r_count - 1'b1;
                                n_out_count = r_count - 1'b1;
                            end
                        end
                        KIND_POP_BACK: begin
                            if (is_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_count     = r_count - 1'b1;
                                n_out_count = r_count - 1'b1;
                            end
                        end
                        KIND_FIND: begin
                            if (is_empty) begin
                                n_status = STATUS_NOT_FOUND;
                            end else begin
                                // result comes from the walk; hold the register
                                n_m_valid  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = r_front;
                                n_slot     = front_inc;
                                n_pos      = CW'(1);
                                n_find_key = in_key;
                                n_state    = ST_SEARCH;
                            end
                        end
                        default: begin
                            // unused codes: no change, plain success
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // rd_key holds the key at r_pos (1-based) from the front
                if (rd_key == r_find_key) begin
                    n_m_valid   = 1'b1;
                    n_status    = STATUS_OK;
                    n_out_count = r_count;
                    n_out_pos   = r_pos;
                    n_state     = ST_IDLE;
                end else if (r_pos == r_count) begin
                    n_m_valid   = 1'b1;
                    n_status    = STATUS_NOT_FOUND;
                    n_out_count = r_count;
                    n_out_pos   = '0;
                    n_state     = ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_slot;
                    n_slot  = slot_inc;
                    n_pos   = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_pos       <= n_pos;
        r_find_key  <= n_find_key;
        r_status    <= n_status;
        r_out_count <= n_out_count;
        r_out_pos   <= n_out_pos;
    end

    bdq_rec_ram #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OW'({r_out_pos, r_out_count, r_status});

    // assertions
    `BDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `BDQ_ASSERT_NOW(a_no_result_mid_search, i_clk, i_rst_n,
        r_state == ST_SEARCH, !r_m_valid)
    `BDQ_ASSERT_NOW(a_search_pos_range, i_clk, i_rst_n,
        r_state == ST_SEARCH, (r_pos != '0) && (r_pos <= r_count))
    `BDQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        s_xfer && !is_full && (in_kind == KIND_PUSH_FRONT || in_kind == KIND_PUSH_BACK),
        r_count == $past(r_count) + 1'b1)
    `BDQ_ASSERT_NEXT(a_search_count_held, i_clk, i_rst_n,
        r_state == ST_SEARCH, r_count == $past(r_count))

endmodule
